FILE: rtl/pf_pkg.sv
// Shared types, constants and helpers for the Playfair digraph cipher.
package pf_pkg;

  localparam int unsigned SIDE    = 5;
  localparam int unsigned CELLS   = SIDE * SIDE;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned SQ_W    = CELLS * CODE_W;
  localparam int unsigned CFG_W   = 50;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CODE_W-1:0] CODE_I = 5'd8;
  localparam logic [CODE_W-1:0] CODE_J = 5'd9;
  localparam logic [CODE_W-1:0] CODE_X = 5'd23;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_MID   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_HIGH  = 2'd3;

  // where one letter sits in the square
  typedef struct packed {
    logic       found;
    logic [2:0] row;
    logic [2:0] col;
  } loc_t;

  // step one place along a row or column, wrapping; back when decrypting
  function automatic logic [2:0] wrap_step(input logic [2:0] pos, input logic dec);
    logic [2:0] res;
    if (dec) begin
      res = (pos == 3'd0) ? 3'd4 : pos - 3'd1;
    end else begin
      res = (pos == 3'd4) ? 3'd0 : pos + 3'd1;
    end
    return res;
  endfunction

  // letter code held at row r, column c
  function automatic logic [CODE_W-1:0] cell_at(input logic [SQ_W-1:0] sq,
                                                input logic [2:0] r,
                                                input logic [2:0] c);
    logic [4:0] idx;
    logic [6:0] base;
    idx  = {r, 2'b00} + {2'b00, r} + {2'b00, c};
    base = {idx, 2'b00} + {2'b00, idx};
    return sq[base +: CODE_W];
  endfunction

endpackage

FILE: rtl/pf_lane.sv
// One search lane: normalises a letter and locates it in the key square.
module pf_lane (
  input  logic                        clk,
  input  logic [pf_pkg::CODE_W-1:0]   letter,
  input  logic [pf_pkg::SQ_W-1:0]     square,
  output pf_pkg::loc_t                loc_r
);

  logic [pf_pkg::CODE_W-1:0] norm;
  pf_pkg::loc_t              loc_nxt;

  assign norm = (letter == pf_pkg::CODE_J) ? pf_pkg::CODE_I : letter;

  // 25 compares in parallel; scanning downwards leaves the lowest match
  always_comb begin
    loc_nxt = '0;
    for (int r = pf_pkg::SIDE - 1; r >= 0; r--) begin
      for (int c = pf_pkg::SIDE - 1; c >= 0; c--) begin
        if (square[(r * pf_pkg::SIDE + c) * pf_pkg::CODE_W +: pf_pkg::CODE_W] == norm) begin
          loc_nxt.found = 1'b1;
          loc_nxt.row   = 3'(r);
          loc_nxt.col   = 3'(c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    loc_r <= loc_nxt;
  end

endmodule

FILE: rtl/pf_merge.sv
// Merge stage: combines both lane locations into the substituted pair.
module pf_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid,
  input  pf_pkg::loc_t                loc_a,
  input  pf_pkg::loc_t                loc_b,
  input  logic                        decrypt,
  input  logic [pf_pkg::SQ_W-1:0]     square,
  output logic                        valid_r,
  output logic [pf_pkg::CODE_W-1:0]   first_r,
  output logic [pf_pkg::CODE_W-1:0]   second_r,
  output logic                        err_r
);

  logic [2:0]                ra, ca, rb, cb;
  logic [pf_pkg::CODE_W-1:0] first_nxt, second_nxt;
  logic                      err_nxt;

  always_comb begin
    ra = loc_a.row;
    ca = loc_a.col;
    rb = loc_b.row;
    cb = loc_b.col;
    if (loc_a.row == loc_b.row) begin
      ca = pf_pkg::wrap_step(loc_a.col, decrypt);
      cb = pf_pkg::wrap_step(loc_b.col, decrypt);
    end else if (loc_a.col == loc_b.col) begin
      ra = pf_pkg::wrap_step(loc_a.row, decrypt);
      rb = pf_pkg::wrap_step(loc_b.row, decrypt);
    end else begin
      ca = loc_b.col;
      cb = loc_a.col;
    end
    err_nxt = !(loc_a.found && loc_b.found);
    if (err_nxt) begin
      first_nxt  = '0;
      second_nxt = '0;
    end else begin
      first_nxt  = pf_pkg::cell_at(square, ra, ca);
      second_nxt = pf_pkg::cell_at(square, rb, cb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
    err_r    <= err_nxt;
  end

endmodule

FILE: rtl/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: config registers, two lanes, merge.
//
// Usage:
//  - Load the finished 5x5 key square through the cfg_ port (index 1..3,
//    row-major, 5-bit codes, cell k at bit 5k of the joined words) and the
//    mode at index 0 (0 encrypt, 1 decrypt). Writes take effect at once;
//    write only while no transaction is in flight.
//  - A pair is taken on any edge with start high and busy low. busy is held
//    low: the block takes one pair every cycle, back to back.
//  - Pipeline: the lane search registers load at the accepting edge, then
//    the merge output register; out_valid comes from the merge register,
//    is high for exactly one cycle per result and qualifies out_first,
//    out_second and out_lookup_error. One result per pair, in order.
//  - Throughput is one pair per cycle, set by the two search lanes each
//    doing a 25-way compare combinationally.
//  - The receiver cannot stall; results must be taken when strobed.
//  - out_lookup_error flags a letter missing from the square; the letters
//    then read zero.
//  - Reset (rst_n low, synchronous) clears the mode, the square and the
//    pipeline valid flags.
module playfair_digraph_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_first_letter,
  input  logic [4:0]  in_second_letter,
  input  logic        in_has_second,
  output logic        out_valid,
  output logic [4:0]  out_first,
  output logic [4:0]  out_second,
  output logic        out_lookup_error,
  input  logic        cfg_we,
  input  logic [pf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pf_pkg::CFG_W-1:0]     cfg_wdata
);

  logic        decrypt_r;
  logic [49:0] sq_low_r, sq_mid_r;
  logic [24:0] sq_high_r;
  logic [pf_pkg::SQ_W-1:0] square;

  logic        accept;
  logic        lane_valid_r;
  logic [4:0]  second_sel;
  pf_pkg::loc_t loc_a, loc_b;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign square = {sq_high_r, sq_mid_r, sq_low_r};

  // odd-length text: pad the pair with X
  assign second_sel = in_has_second ? in_second_letter : pf_pkg::CODE_X;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r <= 1'b0;
      sq_low_r  <= '0;
      sq_mid_r  <= '0;
      sq_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pf_pkg::CFG_DECRYPT_MODE: decrypt_r <= cfg_wdata[0];
        pf_pkg::CFG_SQUARE_LOW:   sq_low_r  <= cfg_wdata;
        pf_pkg::CFG_SQUARE_MID:   sq_mid_r  <= cfg_wdata;
        pf_pkg::CFG_SQUARE_HIGH:  sq_high_r <= cfg_wdata[24:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_valid_r <= 1'b0;
    end else begin
      lane_valid_r <= accept;
    end
  end

  pf_lane u_lane_a (
    .clk    (clk),
    .letter (in_first_letter),
    .square (square),
    .loc_r  (loc_a)
  );

  pf_lane u_lane_b (
    .clk    (clk),
    .letter (second_sel),
    .square (square),
    .loc_r  (loc_b)
  );

  pf_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid    (lane_valid_r),
    .loc_a    (loc_a),
    .loc_b    (loc_b),
    .decrypt  (decrypt_r),
    .square   (square),
    .valid_r  (out_valid),
    .first_r  (out_first),
    .second_r (out_second),
    .err_r    (out_lookup_error)
  );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the Playfair digraph cipher top level.
module tb;

  // one result transaction: two substituted letters and the lookup flag
  typedef struct packed {
    logic [4:0] first;
    logic [4:0] second;
    logic       err;
  } pair_t;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_PAIRS   = 280;
  localparam int unsigned DRAIN_CYCLES  = 3;     // two-stage pipe plus one spare

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [4:0]  in_first_letter;
  logic [4:0]  in_second_letter;
  logic        in_has_second;
  logic        out_valid;
  logic [4:0]  out_first;
  logic [4:0]  out_second;
  logic        out_lookup_error;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [49:0] cfg_wdata;

  // mirror of the block's registers: the whole square as 25 packed cells
  logic [pf_pkg::SQ_W-1:0] key_sq  = '0;
  logic                    key_dec = 1'b0;

  pair_t       pending_pairs[$];
  pair_t       due_pair;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  playfair_digraph_cipher u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_letter  (in_first_letter),
    .in_second_letter (in_second_letter),
    .in_has_second    (in_has_second),
    .out_valid        (out_valid),
    .out_first        (out_first),
    .out_second       (out_second),
    .out_lookup_error (out_lookup_error),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // letter code from an upper-case character
  function automatic logic [4:0] ltr(input byte ch);
    return 5'(ch - "A");
  endfunction

  // Expected transaction for one pair under the current mirror.
  // A letter is taken at its lowest-numbered cell; J folds onto I first.
  function automatic pair_t cipher_pair(input logic [4:0] fl, input logic [4:0] sl,
                                        input logic hs);
    logic [4:0] a;
    logic [4:0] b;
    int         k;
    int         ka;
    int         kb;
    int         r1;
    int         c1;
    int         r2;
    int         c2;
    int         stp;
    pair_t      res;
    a = fl;
    b = hs ? sl : pf_pkg::CODE_X;
    if (a == pf_pkg::CODE_J) a = pf_pkg::CODE_I;
    if (b == pf_pkg::CODE_J) b = pf_pkg::CODE_I;
    ka = -1;
    kb = -1;
    for (k = pf_pkg::CELLS - 1; k >= 0; k--) begin
      if (key_sq[5*k +: 5] == a) ka = k;
      if (key_sq[5*k +: 5] == b) kb = k;
    end
    res = '0;
    if (ka < 0 || kb < 0) begin
      res.err = 1'b1;
      return res;
    end
    r1  = ka / 5;
    c1  = ka % 5;
    r2  = kb / 5;
    c2  = kb % 5;
    stp = key_dec ? 4 : 1;      // stepping back is four steps forward mod 5
    if (r1 == r2) begin
      // same row, and also the same cell twice
      res.first  = key_sq[5*(r1*5 + (c1+stp)%5) +: 5];
      res.second = key_sq[5*(r2*5 + (c2+stp)%5) +: 5];
    end else if (c1 == c2) begin
      res.first  = key_sq[5*(((r1+stp)%5)*5 + c1) +: 5];
      res.second = key_sq[5*(((r2+stp)%5)*5 + c2) +: 5];
    end else begin
      // rectangle: each letter keeps its row and takes the other's column
      res.first  = key_sq[5*(r1*5 + c2) +: 5];
      res.second = key_sq[5*(r2*5 + c1) +: 5];
    end
    return res;
  endfunction

  // Biased letter source: mostly codes that sit in the current square, so
  // most pairs resolve, with J, plain letters and out-of-range codes mixed in.
  function automatic logic [4:0] pick_letter();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return key_sq[5*$urandom_range(pf_pkg::CELLS-1) +: 5];
    if (r < 85) return pf_pkg::CODE_J;
    if (r < 95) return 5'($urandom_range(25));
    return 5'($urandom_range(31));
  endfunction

  // Offer one pair and hold it until the block takes it. start is left high
  // so that back-to-back transactions need no extra cycle.
  task automatic send_pair(input logic [4:0] fl, input logic [4:0] sl, input logic hs);
    start            <= 1'b1;
    in_first_letter  <= fl;
    in_second_letter <= sl;
    in_has_second    <= hs;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_pairs.push_back(cipher_pair(fl, sl, hs));
  endtask

  // random sender gap, taken with the given percentage
  task automatic maybe_pause(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected transaction has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back. Bits above a register's width
  // carry junk; the block must drop them.
  task automatic load_key(input logic dec, input logic [pf_pkg::SQ_W-1:0] sq);
    logic [63:0] junk;
    junk      = {$urandom, $urandom};
    cfg_we    <= 1'b1;
    cfg_index <= pf_pkg::CFG_DECRYPT_MODE;
    cfg_wdata <= {junk[49:1], dec};
    @(posedge clk);
    key_dec   = dec;
    cfg_index <= pf_pkg::CFG_SQUARE_LOW;
    cfg_wdata <= sq[49:0];
    @(posedge clk);
    key_sq[49:0] = sq[49:0];
    cfg_index <= pf_pkg::CFG_SQUARE_MID;
    cfg_wdata <= sq[99:50];
    @(posedge clk);
    key_sq[99:50] = sq[99:50];
    cfg_index <= pf_pkg::CFG_SQUARE_HIGH;
    cfg_wdata <= {junk[24:0], sq[124:100]};
    @(posedge clk);
    key_sq[124:100] = sq[124:100];
    cfg_we <= 1'b0;
  endtask

  // After reset the square is all A and the mode is encrypt: A pairs with
  // itself at cell 0, anything else misses.
  task automatic test_reset_state();
    send_pair(ltr("A"), ltr("A"), 1'b1);
    send_pair(ltr("B"), ltr("A"), 1'b1);
    send_pair(ltr("A"), 5'd31, 1'b0);
  endtask

  // Alphabetical square without J, both directions: rows, columns, wraps,
  // rectangle, J folding, missing second letter, repeated letter, misses.
  task automatic test_classic_rules();
    logic [pf_pkg::SQ_W-1:0] sq;
    int                      k;
    for (k = 0; k < pf_pkg::CELLS; k++) sq[5*k +: 5] = 5'((k < 9) ? k : k + 1);
    for (k = 0; k < 2; k++) begin
      drain();
      load_key(k[0], sq);
      send_pair(ltr("A"), ltr("C"), 1'b1);   // same row
      send_pair(ltr("D"), ltr("E"), 1'b1);   // same row, wraps
      send_pair(ltr("A"), ltr("F"), 1'b1);   // same column
      send_pair(ltr("Q"), ltr("V"), 1'b1);   // same column, wraps
      send_pair(ltr("A"), ltr("G"), 1'b1);   // rectangle
      send_pair(ltr("J"), ltr("K"), 1'b1);   // J read as I
      send_pair(ltr("M"), ltr("M"), 1'b1);   // both in one cell
      send_pair(ltr("Z"), 5'd31, 1'b0);      // odd length: second is X
      send_pair(5'd31, ltr("A"), 1'b1);      // first letter out of range
      send_pair(ltr("Z"), 5'd30, 1'b1);      // second letter out of range
    end
  endtask

  // Squares software should never load: all-zero, all-ones, duplicates,
  // a stored J and codes above Z.
  task automatic test_odd_squares();
    logic [pf_pkg::SQ_W-1:0] sq;
    drain();
    load_key(1'b0, '0);
    send_pair(ltr("A"), ltr("Z"), 1'b1);
    drain();
    load_key(1'b1, '1);
    send_pair(5'd31, 5'd31, 1'b1);
    send_pair(ltr("A"), 5'd31, 1'b0);
    sq = '0;
    sq[4:0]   = 5'd31;
    sq[9:5]   = pf_pkg::CODE_J;
    sq[14:10] = pf_pkg::CODE_I;
    sq[19:15] = pf_pkg::CODE_I;
    drain();
    load_key(1'b1, sq);
    send_pair(ltr("J"), 5'd31, 1'b1);      // I found at its first cell
    send_pair(ltr("A"), 5'd31, 1'b1);
  endtask

  // Random phases: three sender idling rates, each with an encrypt and a
  // decrypt phase. Raw squares give duplicates and codes above Z.
  task automatic test_random_phases();
    logic [pf_pkg::SQ_W-1:0] sq;
    logic [4:0]              cell_codes[25];
    logic [4:0]              tmp;
    int unsigned             idle_pct;
    int                      p;
    int                      n;
    int                      k;
    int                      j;
    for (p = 0; p < 6; p++) begin
      if (p == 2 || p == 5) begin
        for (k = 0; k < pf_pkg::CELLS; k++) sq[5*k +: 5] = 5'($urandom);
      end else begin
        // well-formed key: shuffled alphabet without J
        for (k = 0; k < pf_pkg::CELLS; k++) cell_codes[k] = 5'((k < 9) ? k : k + 1);
        for (k = pf_pkg::CELLS - 1; k > 0; k--) begin
          j             = $urandom_range(k);
          tmp           = cell_codes[k];
          cell_codes[k] = cell_codes[j];
          cell_codes[j] = tmp;
        end
        for (k = 0; k < pf_pkg::CELLS; k++) sq[5*k +: 5] = cell_codes[k];
      end
      idle_pct = (p < 2) ? 6 : (p < 4) ? 52 : 0;
      drain();
      load_key(p[0], sq);
      for (n = 0; n < PHASE_PAIRS; n++) begin
        maybe_pause(idle_pct);
        send_pair(pick_letter(), pick_letter(), ($urandom_range(9) != 0));
      end
    end
  endtask

  // Result checker: every strobed transaction is matched against the oldest
  // expectation. Sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: result with nothing expected: first %0d second %0d err %0b",
                 $time, out_first, out_second, out_lookup_error);
        mismatches++;
      end else begin
        due_pair = pending_pairs.pop_front();
        if (out_first !== due_pair.first) begin
          $display("%0t: out_first expected %0d actual %0d",
                   $time, due_pair.first, out_first);
          mismatches++;
        end
        if (out_second !== due_pair.second) begin
          $display("%0t: out_second expected %0d actual %0d",
                   $time, due_pair.second, out_second);
          mismatches++;
        end
        if (out_lookup_error !== due_pair.err) begin
          $display("%0t: out_lookup_error expected %0b actual %0b",
                   $time, due_pair.err, out_lookup_error);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_first_letter  <= '0;
    in_second_letter <= '0;
    in_has_second    <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= pf_pkg::CFG_DECRYPT_MODE;
    cfg_wdata        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_classic_rules();
    test_odd_squares();
    test_random_phases();
    drain();

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
